// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk and disabled during rst
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define LZ_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LZ_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define LZ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/lzssd_pkg.sv =====
// ---------------------------------------------------------------------------
// lzssd_pkg
// shared types and codes of the lzss stream decompressor
// ---------------------------------------------------------------------------
package lzssd_pkg;

  // parse phase of the token stream
  typedef enum logic [1:0] {
    PH_FLAG   = 2'd0,
    PH_TOKEN  = 2'd1,
    PH_MATCH2 = 2'd2
  } phase_t;

  // status codes of the end-of-stream result
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CAPACITY = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_DISTANCE = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAPACITY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SIZE = 1'b1;

  // token field layout
  localparam int LOOKSHIFT = 4;
  localparam logic [LOOKSHIFT-1:0] LEN_MASK = 4'hF;
  localparam int TOKEN_IDX_W = 3;
  localparam int COUNT_W = LOOKSHIFT + 1;

  // one result item
  typedef struct packed {
    logic [7:0] data;
    logic       is_status;
    logic [1:0] status;
    logic       last;
  } res_t;

endpackage

// ===== rtl/core/lzssd_hist_mem.sv =====
// ---------------------------------------------------------------------------
// lzssd_hist_mem
// history window: one write port, one registered read port, write-to-read
// forwarding when both ports hit the same entry in one cycle
// ---------------------------------------------------------------------------
module lzssd_hist_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_q;
  logic       fwd;
  logic [7:0] fwd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      fwd      <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  assign rd_data = fwd ? fwd_data : rd_q;

endmodule

// ===== rtl/core/lzssd_out_fifo.sv =====
// ---------------------------------------------------------------------------
// lzssd_out_fifo
// two-entry result queue between the decoder and the output channel
// ---------------------------------------------------------------------------
module lzssd_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lzssd_pkg::res_t   push_item,
  input  logic              out_stall,
  output logic              out_valid,
  output lzssd_pkg::res_t   out_item,
  output logic              pop,
  output logic [1:0]        count
);

  lzssd_pkg::res_t entries [2];
  logic            rd_ptr;
  logic            wr_ptr;
  logic [1:0]      count_next;

  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_item  = entries[rd_ptr];

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/core/lzss_stream_decompressor_core.sv =====
// ---------------------------------------------------------------------------
// lzss_stream_decompressor_core
// lzss token decoder (12-bit distance, 4-bit length) over a history memory
// ---------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  in       | in_valid / in_stall    | in_byte, stream_start
//  out      | out_valid / out_stall  | out_byte, is_status, status, last
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  flag bytes, literals and first match bytes are handled in the cycle that accepts them
//  a match's second byte starts a copy of n bytes: one history read per cycle on the
//  single read port while the result queue has room, each byte written behind and
//  emitted as it returns from the registered read port; input stalls during the copy
//  out_stall pauses the copy; a two-entry result queue decouples the sides
//  no clearing pass after reset: history entries are undefined until written
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lzss_stream_decompressor_core #(
  parameter int WINDOW_DEPTH = 4096,
  parameter int SIZE_BITS    = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_byte,
  input  logic                              stream_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_byte,
  output logic                              is_status,
  output logic [1:0]                        status,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lzssd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lzssd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int DW = 2 * lzssd_pkg::LOOKSHIFT + 4;  // distance field width

  // parse state
  lzssd_pkg::phase_t                    phase, phase_next;
  logic [7:0]                           flag_bits, flag_bits_next;
  logic [lzssd_pkg::TOKEN_IDX_W-1:0]    token_index, token_index_next;
  logic [7:0]                           dist_high, dist_high_next;
  logic                                 finished, finished_next;
  logic [AW-1:0]                        wp, wp_next;
  logic [SIZE_BITS-1:0]                 total_bytes, total_bytes_next;

  // copy engine
  logic                                 copy_active, copy_active_next;
  logic [AW-1:0]                        copy_src, copy_src_next;
  logic [lzssd_pkg::COUNT_W-1:0]        copy_left, copy_left_next;
  logic                                 rd_pend, rd_last, rd_last_next;
  logic                                 copy_issue;

  // configuration
  logic [SIZE_BITS-1:0]                 out_capacity;
  logic [SIZE_BITS-1:0]                 expected_size;

  // memory and queue hookup
  logic                                 mem_wr_en;
  logic [AW-1:0]                        mem_wr_addr;
  logic [7:0]                           mem_wr_data;
  logic [7:0]                           mem_rd_data;
  logic                                 fifo_push;
  lzssd_pkg::res_t                      push_item;
  lzssd_pkg::res_t                      out_item;
  logic                                 fifo_pop;
  logic [1:0]                           fifo_count;
  logic [1:0]                           occ;

  // token decode helpers
  logic                                 accept;
  lzssd_pkg::phase_t                    eff_phase;
  logic                                 eff_finished;
  logic [DW-1:0]                        dist_m1;
  logic [DW:0]                          match_dist;
  logic [lzssd_pkg::COUNT_W-1:0]        count;
  logic [SIZE_BITS:0]                   total_plus_one;
  logic [SIZE_BITS:0]                   total_plus_count;

  assign cfg_ready = 1'b1;

  assign occ        = fifo_count + {1'b0, rd_pend};
  assign copy_issue = copy_active && ((occ < 2'd2) || ((occ == 2'd2) && fifo_pop));
  assign in_stall   = copy_active || rd_pend || (fifo_count == 2'd2);
  assign accept     = in_valid && !in_stall;

  assign eff_phase    = stream_start ? lzssd_pkg::PH_FLAG : phase;
  assign eff_finished = stream_start ? 1'b0 : finished;

  assign dist_m1          = {dist_high, in_byte[7:lzssd_pkg::LOOKSHIFT]};
  assign match_dist       = {1'b0, dist_m1} + (DW+1)'(1);
  assign count            = {1'b0, in_byte[lzssd_pkg::LOOKSHIFT-1:0]}
                            + lzssd_pkg::COUNT_W'(1);
  assign total_plus_one   = {1'b0, total_bytes} + (SIZE_BITS+1)'(1);
  assign total_plus_count = {1'b0, total_bytes} + (SIZE_BITS+1)'(count);

  always_comb begin
    phase_next       = phase;
    flag_bits_next   = flag_bits;
    token_index_next = token_index;
    dist_high_next   = dist_high;
    finished_next    = finished;
    wp_next          = wp;
    total_bytes_next = total_bytes;
    copy_active_next = copy_active;
    copy_src_next    = copy_src;
    copy_left_next   = copy_left;
    rd_last_next     = rd_last;
    mem_wr_en        = 1'b0;
    mem_wr_addr      = wp;
    mem_wr_data      = in_byte;
    fifo_push        = 1'b0;
    push_item        = '0;

    // copy engine: issue reads
    if (copy_issue) begin
      copy_src_next  = copy_src + AW'(1);
      copy_left_next = copy_left - lzssd_pkg::COUNT_W'(1);
      rd_last_next   = (copy_left == lzssd_pkg::COUNT_W'(1));
      if (copy_left == lzssd_pkg::COUNT_W'(1)) copy_active_next = 1'b0;
    end

    // copy engine: read data comes back, write it behind and emit it
    if (rd_pend) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = wp;
      mem_wr_data = mem_rd_data;
      wp_next     = wp + AW'(1);
      fifo_push   = 1'b1;
      push_item   = '{data: mem_rd_data, is_status: 1'b0,
                      status: lzssd_pkg::ST_OK, last: rd_last};
    end

    if (accept) begin
      if (stream_start) begin
        phase_next       = lzssd_pkg::PH_FLAG;
        flag_bits_next   = 8'h00;
        token_index_next = '0;
        dist_high_next   = 8'h00;
        finished_next    = 1'b0;
        wp_next          = '0;
        total_bytes_next = '0;
      end
      if (!eff_finished) begin
        if (expected_size > out_capacity) begin
          fifo_push     = 1'b1;
          push_item     = '{data: 8'h00, is_status: 1'b1,
                            status: lzssd_pkg::ST_CAPACITY, last: 1'b1};
          finished_next = 1'b1;
        end else begin
          case (eff_phase)
            lzssd_pkg::PH_TOKEN: begin
              if (flag_bits[0]) begin
                dist_high_next = in_byte;
                phase_next     = lzssd_pkg::PH_MATCH2;
              end else if (total_plus_one > {1'b0, out_capacity}) begin
                fifo_push     = 1'b1;
                push_item     = '{data: 8'h00, is_status: 1'b1,
                                  status: lzssd_pkg::ST_CAPACITY, last: 1'b1};
                finished_next = 1'b1;
              end else begin
                mem_wr_en        = 1'b1;
                mem_wr_addr      = wp;
                mem_wr_data      = in_byte;
                wp_next          = wp + AW'(1);
                total_bytes_next = total_plus_one[SIZE_BITS-1:0];
                fifo_push        = 1'b1;
                push_item        = '{data: in_byte, is_status: 1'b0,
                                     status: lzssd_pkg::ST_OK, last: 1'b1};
                flag_bits_next   = flag_bits >> 1;
                token_index_next = token_index + lzssd_pkg::TOKEN_IDX_W'(1);
                phase_next       = (token_index == '1) ? lzssd_pkg::PH_FLAG
                                                       : lzssd_pkg::PH_TOKEN;
              end
            end
            lzssd_pkg::PH_MATCH2: begin
              if ((in_byte[lzssd_pkg::LOOKSHIFT-1:0] & lzssd_pkg::LEN_MASK) == '0) begin
                // end token
                fifo_push     = 1'b1;
                push_item     = '{data: 8'h00, is_status: 1'b1,
                                  status: (total_bytes == expected_size)
                                          ? lzssd_pkg::ST_OK : lzssd_pkg::ST_MISMATCH,
                                  last: 1'b1};
                finished_next = 1'b1;
              end else if (SIZE_BITS'(match_dist) > total_bytes) begin
                fifo_push     = 1'b1;
                push_item     = '{data: 8'h00, is_status: 1'b1,
                                  status: lzssd_pkg::ST_DISTANCE, last: 1'b1};
                finished_next = 1'b1;
              end else if (total_plus_count > {1'b0, out_capacity}) begin
                fifo_push     = 1'b1;
                push_item     = '{data: 8'h00, is_status: 1'b1,
                                  status: lzssd_pkg::ST_CAPACITY, last: 1'b1};
                finished_next = 1'b1;
              end else begin
                copy_active_next = 1'b1;
                copy_src_next    = wp - AW'(match_dist);
                copy_left_next   = count;
                total_bytes_next = total_plus_count[SIZE_BITS-1:0];
                flag_bits_next   = flag_bits >> 1;
                token_index_next = token_index + lzssd_pkg::TOKEN_IDX_W'(1);
                phase_next       = (token_index == '1) ? lzssd_pkg::PH_FLAG
                                                       : lzssd_pkg::PH_TOKEN;
              end
            end
            default: begin
              // flag byte
              flag_bits_next = in_byte;
              phase_next     = lzssd_pkg::PH_TOKEN;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= lzssd_pkg::PH_FLAG;
      flag_bits     <= 8'h00;
      token_index   <= '0;
      dist_high     <= 8'h00;
      finished      <= 1'b0;
      wp            <= '0;
      total_bytes   <= '0;
      copy_active   <= 1'b0;
      rd_pend       <= 1'b0;
      out_capacity  <= '0;
      expected_size <= '0;
    end else begin
      phase       <= phase_next;
      flag_bits   <= flag_bits_next;
      token_index <= token_index_next;
      dist_high   <= dist_high_next;
      finished    <= finished_next;
      wp          <= wp_next;
      total_bytes <= total_bytes_next;
      copy_active <= copy_active_next;
      rd_pend     <= copy_issue;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lzssd_pkg::CFG_OUT_CAPACITY:  out_capacity  <= cfg_data[SIZE_BITS-1:0];
          lzssd_pkg::CFG_EXPECTED_SIZE: expected_size <= cfg_data[SIZE_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    copy_src  <= copy_src_next;
    copy_left <= copy_left_next;
    rd_last   <= rd_last_next;
  end

  lzssd_hist_mem #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_hist (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (copy_issue),
    .rd_addr (copy_src),
    .rd_data (mem_rd_data)
  );

  lzssd_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (fifo_push),
    .push_item (push_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .pop       (fifo_pop),
    .count     (fifo_count)
  );

  assign out_byte  = out_item.data;
  assign is_status = out_item.is_status;
  assign status    = out_item.status;
  assign last      = out_item.last;

  `LZ_ASSERT_IMPLIES(a_queue_no_overflow, fifo_count == 2'd2 && !fifo_pop, !fifo_push, "overflow")
  `LZ_ASSERT_NEXT(a_status_finishes, fifo_push && push_item.is_status, finished, "no finish")
  `LZ_ASSERT_IMPLIES(a_copy_not_finished, copy_active, !finished, "copy after finish")
  `LZ_ASSERT_IMPLIES(a_copy_tail_read, !$past(rst) && $fell(copy_active), rd_pend, "no tail read")

endmodule
